>>> sv/utf8d_pkg.sv
// utf8d_pkg: shared types, constants and the lead byte classifier
// for the lenient utf-8 decoder; no dependencies
package utf8d_pkg;

    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int MAX_RES   = 4;
    localparam int CNT_W     = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] MASK_B7   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_TOP3 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_2    = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_TOP4 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_TOP5 = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_3    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4    = 8'hF0;
    localparam logic [BYTE_W-1:0] PAY_2     = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY_3     = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY_4     = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_CONT  = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_TOP2 = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_RAW
    } lead_kind_t;

    typedef struct packed {
        logic [MAX_RES-1:0][CP_W-1:0] cp;
        logic [CNT_W-1:0]             n;
        logic                         eos;
    } group_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic lead_kind_t classify(input logic [BYTE_W-1:0] b);
        lead_kind_t k;
        if ((b & MASK_B7) == 8'h00) begin
            k = KIND_ASCII;
        end else if ((b & MASK_TOP3) == LEAD_2) begin
            k = KIND_LEAD2;
        end else if ((b & MASK_TOP4) == LEAD_3) begin
            k = KIND_LEAD3;
        end else if ((b & MASK_TOP5) == LEAD_4) begin
            k = KIND_LEAD4;
        end else begin
            k = KIND_RAW;
        end
        return k;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & MASK_TOP2) == CONT_TAG;
    endfunction

endpackage

>>> sv/utf8d_front.sv
// utf8d_front: sequence state and per-byte result group builder
// depends on utf8d_pkg
module utf8d_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          eos,
    output utf8d_pkg::group_t             grp,
    output logic                          push
);

    logic [utf8d_pkg::BYTE_W-1:0] lead_reg, lead_next;
    logic [2:0]                   exp_reg, exp_next;
    logic [1:0]                   rc_reg, rc_next;
    logic [utf8d_pkg::CP_W-1:0]   acc_reg, acc_next;
    logic [utf8d_pkg::BYTE_W-1:0] pend_reg [2];
    logic [utf8d_pkg::BYTE_W-1:0] pend_next [2];

    logic [utf8d_pkg::MAX_RES-1:0][utf8d_pkg::CP_W-1:0] cps;
    logic [utf8d_pkg::CNT_W-1:0]  n_c;
    logic [utf8d_pkg::CP_W-1:0]   acc_sh;
    logic                         do_lead;
    utf8d_pkg::lead_kind_t        kind;

    assign acc_sh = {acc_reg[utf8d_pkg::CP_W-7:0], data_byte[5:0]};
    assign kind   = utf8d_pkg::classify(data_byte);

    always_comb begin
        lead_next    = lead_reg;
        exp_next     = exp_reg;
        rc_next      = rc_reg;
        acc_next     = acc_reg;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        cps          = '0;
        n_c          = '0;
        do_lead      = 1'b0;

        if (exp_reg == utf8d_pkg::LEN_NONE) begin
            do_lead = 1'b1;
        end else if (utf8d_pkg::is_cont(data_byte)) begin
            if ({1'b0, rc_reg} + 3'd2 >= exp_reg) begin
                cps[0]   = acc_sh;
                n_c      = 3'd1;
                exp_next = utf8d_pkg::LEN_NONE;
                rc_next  = 2'd0;
                acc_next = '0;
            end else if (eos) begin
                // cut off at end: lead, the buffered byte if any, then this byte
                cps[0] = {13'd0, lead_reg};
                n_c    = 3'd1;
                if (rc_reg >= 2'd1) begin
                    cps[n_c[1:0]] = {13'd0, pend_reg[0]};
                    n_c = n_c + 3'd1;
                end
                cps[n_c[1:0]] = {13'd0, data_byte};
                n_c      = n_c + 3'd1;
                exp_next = utf8d_pkg::LEN_NONE;
                rc_next  = 2'd0;
                acc_next = '0;
            end else begin
                pend_next[rc_reg[0]] = data_byte;
                rc_next  = rc_reg + 2'd1;
                acc_next = acc_sh;
            end
        end else begin
            // broken sequence: flush raw, then treat byte as a new lead
            cps[0] = {13'd0, lead_reg};
            n_c    = 3'd1;
            if (rc_reg >= 2'd1) begin
                cps[n_c[1:0]] = {13'd0, pend_reg[0]};
                n_c = n_c + 3'd1;
            end
            if (rc_reg >= 2'd2) begin
                cps[n_c[1:0]] = {13'd0, pend_reg[1]};
                n_c = n_c + 3'd1;
            end
            exp_next = utf8d_pkg::LEN_NONE;
            rc_next  = 2'd0;
            acc_next = '0;
            do_lead  = 1'b1;
        end

        if (do_lead) begin
            unique case (kind)
                utf8d_pkg::KIND_ASCII, utf8d_pkg::KIND_RAW: begin
                    cps[n_c[1:0]] = {13'd0, data_byte};
                    n_c = n_c + 3'd1;
                end
                default: begin
                    lead_next = data_byte;
                    rc_next   = 2'd0;
                    if (kind == utf8d_pkg::KIND_LEAD2) begin
                        exp_next = utf8d_pkg::LEN_2;
                        acc_next = {13'd0, data_byte & utf8d_pkg::PAY_2};
                    end else if (kind == utf8d_pkg::KIND_LEAD3) begin
                        exp_next = utf8d_pkg::LEN_3;
                        acc_next = {13'd0, data_byte & utf8d_pkg::PAY_3};
                    end else begin
                        exp_next = utf8d_pkg::LEN_4;
                        acc_next = {13'd0, data_byte & utf8d_pkg::PAY_4};
                    end
                    if (eos) begin
                        cps[n_c[1:0]] = {13'd0, data_byte};
                        n_c      = n_c + 3'd1;
                        exp_next = utf8d_pkg::LEN_NONE;
                        acc_next = '0;
                    end
                end
            endcase
        end
    end

    assign grp.cp  = cps;
    assign grp.n   = n_c;
    assign grp.eos = eos;
    assign push    = accept && (n_c != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= '0;
            exp_reg  <= utf8d_pkg::LEN_NONE;
            rc_reg   <= '0;
            acc_reg  <= '0;
        end else if (accept) begin
            lead_reg <= lead_next;
            exp_reg  <= exp_next;
            rc_reg   <= rc_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg[0] <= pend_next[0];
            pend_reg[1] <= pend_next[1];
        end
    end

endmodule

>>> sv/utf8d_queue.sv
// utf8d_queue: short queue of result groups between front and back
// depends on utf8d_pkg
module utf8d_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  utf8d_pkg::group_t      wr_grp,
    input  logic                   pop,
    output utf8d_pkg::group_t      rd_grp,
    output utf8d_pkg::q_status_t   status
);

    utf8d_pkg::group_t              mem [utf8d_pkg::Q_DEPTH];
    logic [utf8d_pkg::Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [utf8d_pkg::Q_PTR_W:0]    count_reg, count_next;

    assign rd_grp       = mem[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.full  = count_reg == (utf8d_pkg::Q_PTR_W+1)'(utf8d_pkg::Q_DEPTH);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

>>> sv/utf8d_back.sv
// utf8d_back: splits queued groups into single result beats
// depends on utf8d_pkg
module utf8d_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  utf8d_pkg::group_t            grp,
    input  utf8d_pkg::q_status_t         q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [utf8d_pkg::CP_W-1:0]   out_cp,
    output logic                         out_last_item,
    output logic                         out_last_string
);

    logic [1:0]                 idx_reg;
    logic                       valid_reg;
    logic [utf8d_pkg::CP_W-1:0] cp_reg;
    logic                       li_reg, ls_reg;
    logic                       take, last;

    assign take = q_status.valid && (!valid_reg || out_ready);
    assign last = (grp.n - 3'd1) == {1'b0, idx_reg};
    assign pop  = take && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cp_reg <= grp.cp[idx_reg];
            li_reg <= last;
            ls_reg <= last && grp.eos;
        end
    end

    assign out_valid       = valid_reg;
    assign out_cp          = cp_reg;
    assign out_last_item   = li_reg;
    assign out_last_string = ls_reg;

endmodule

>>> sv/utf8_lenient_decoder.sv
// utf8_lenient_decoder: top level of the lenient utf-8 to code point decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
//  channel | direction | tdata                  | tuser         | tlast
//  s_      | in        | [7:0] data_byte        | -             | end_of_string
//  m_      | out       | [20:0] code_point      | last_of_item  | last_of_string
//
// one input byte accepted per cycle while the 4-group queue has room
// each byte yields 0 to 4 result beats; the back end sends one beat per cycle
// while the queue holds a group and m_tready is high
// a byte's results pass through the queue entry and then the output register
// synchronous active-low reset clears sequence state, queue and output valid
module utf8_lenient_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tuser,   // [0] last_of_item
    output logic        m_tlast
);

    utf8d_pkg::group_t          f_grp, q_grp;
    utf8d_pkg::q_status_t       q_status;
    logic                       accept, push, pop;
    logic [utf8d_pkg::CP_W-1:0] cp;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    utf8d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .eos       (s_tlast),
        .grp       (f_grp),
        .push      (push)
    );

    utf8d_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_grp  (f_grp),
        .pop     (pop),
        .rd_grp  (q_grp),
        .status  (q_status)
    );

    utf8d_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .grp             (q_grp),
        .q_status        (q_status),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_cp          (cp),
        .out_last_item   (m_tuser),
        .out_last_string (m_tlast)
    );

    assign m_tdata = {{(utf8d_pkg::M_TDATA_W - utf8d_pkg::CP_W){1'b0}}, cp};

    a_last_string_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("string end on a beat that does not end its byte");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("queue overflow");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.valid)
        else $error("queue underflow");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
